// ----- hdl/ps2mpt_pkg.sv -----
// Shared constants and types for the PS/2 mouse packet tracker.
`default_nettype none
package ps2mpt_pkg;

   localparam int SCREEN_WIDTH_DEFAULT  = 640;
   localparam int SCREEN_HEIGHT_DEFAULT = 480;
   localparam int CURSOR_X_RESET        = 320;
   localparam int CURSOR_Y_RESET        = 240;

   // Header byte bit positions
   localparam int HDR_SYNC_BIT   = 3;
   localparam int HDR_XSIGN_BIT  = 4;
   localparam int HDR_YSIGN_BIT  = 5;
   localparam int HDR_XOVF_BIT   = 6;
   localparam int HDR_YOVF_BIT   = 7;

   localparam int POS_X_W  = 10;
   localparam int POS_Y_W  = 9;
   localparam int BTN_W    = 3;
   localparam int SCROLL_W = 16;

   // Byte counts
   localparam logic [1:0] CNT_FIRST     = 2'd0;
   localparam logic [1:0] CNT_LAST_STD  = 2'd2;
   localparam logic [1:0] CNT_LAST_WHL  = 2'd3;

   // Completed packet handed from the assembler to the tracker
   typedef struct packed {
      logic             fire;
      logic [BTN_W-1:0] buttons;
      logic             x_sign;
      logic [7:0]       x_lo;
      logic             y_sign;
      logic [7:0]       y_lo;
      logic             scroll_en;
      logic [7:0]       scroll_byte;
   } pkt_type;

endpackage
`default_nettype wire

// ----- hdl/ps2mpt_ifs.sv -----
// Channel interfaces for the PS/2 mouse packet tracker.
`default_nettype none
interface ps2mpt_req_if;
   logic       valid;
   logic       ready;
   logic       from_aux;
   logic [7:0] data_byte;
   modport source (output valid, output from_aux, output data_byte, input ready);
   modport sink   (input valid, input from_aux, input data_byte, output ready);
endinterface

interface ps2mpt_rsp_if;
   logic                valid;
   logic                ready;
   logic [9:0]          pos_x;
   logic [8:0]          pos_y;
   logic [2:0]          button_bits;
   logic [2:0]          last_button_bits;
   logic signed [15:0]  scroll_total;
   modport source (output valid, output pos_x, output pos_y, output button_bits,
                   output last_button_bits, output scroll_total, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input button_bits,
                   input last_button_bits, input scroll_total, output ready);
endinterface

interface ps2mpt_csr_if;
   logic valid;
   logic ready;
   logic wheel_mode;
   modport source (output valid, output wheel_mode, input ready);
   modport sink   (input valid, input wheel_mode, output ready);
endinterface
`default_nettype wire

// ----- hdl/ps2mpt_assembler.sv -----
// Input register and packet byte assembly with header sync.
`default_nettype none
module ps2mpt_assembler (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               from_aux,
   input  wire logic [7:0]         data_byte,
   input  wire logic               wheel_mode,
   input  wire logic               stall,
   output ps2mpt_pkg::pkt_type     pkt
);
   import ps2mpt_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic       aux_ff;
   logic [7:0] data_ff;
   logic [1:0] byte_count_ff, byte_count_in;
   logic [7:0] packet_store_ff [3];

   logic       advance;
   logic       act;
   logic [1:0] last_index;
   logic       do_store;
   logic       do_finish;
   logic [7:0] head;

   assign advance    = in_valid_ff & ~stall;
   assign req_ready  = ~in_valid_ff | ~stall;
   assign act        = advance & aux_ff;
   assign last_index = wheel_mode ? CNT_LAST_WHL : CNT_LAST_STD;

   always_comb begin
      do_store  = 1'b0;
      do_finish = 1'b0;
      if (act) begin
         if (byte_count_ff == CNT_FIRST && !data_ff[HDR_SYNC_BIT]) begin
            do_store = 1'b0;           // out of sync, drop
         end else if (byte_count_ff < last_index && byte_count_ff != CNT_LAST_WHL) begin
            do_store = 1'b1;
         end else begin
            do_finish = 1'b1;
         end
      end
   end

   always_comb begin
      byte_count_in = byte_count_ff;
      if (do_store) begin
         byte_count_in = byte_count_ff + 2'd1;
      end else if (do_finish) begin
         byte_count_in = CNT_FIRST;
      end
   end

   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         byte_count_ff <= CNT_FIRST;
      end else begin
         in_valid_ff   <= in_valid_in;
         byte_count_ff <= byte_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         aux_ff  <= from_aux;
         data_ff <= data_byte;
      end
      if (do_store) begin
         packet_store_ff[byte_count_ff] <= data_ff;
      end
   end

   // Completed packet; in standard mode the final byte is still in the input reg
   assign head = packet_store_ff[0];
   always_comb begin
      pkt.fire        = do_finish & ~head[HDR_XOVF_BIT] & ~head[HDR_YOVF_BIT];
      pkt.buttons     = head[BTN_W-1:0];
      pkt.x_sign      = head[HDR_XSIGN_BIT];
      pkt.x_lo        = packet_store_ff[1];
      pkt.y_sign      = head[HDR_YSIGN_BIT];
      pkt.y_lo        = (byte_count_ff == CNT_LAST_STD) ? data_ff : packet_store_ff[2];
      pkt.scroll_en   = wheel_mode;
      pkt.scroll_byte = data_ff;
   end

endmodule
`default_nettype wire

// ----- hdl/ps2mpt_tracker.sv -----
// Cursor, button and scroll state; doubles as the result register.
`default_nettype none
module ps2mpt_tracker #(
   parameter int SCREEN_WIDTH  = ps2mpt_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = ps2mpt_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ps2mpt_pkg::pkt_type           pkt,
   output logic                               stall,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [ps2mpt_pkg::POS_X_W-1:0]     pos_x,
   output logic [ps2mpt_pkg::POS_Y_W-1:0]     pos_y,
   output logic [ps2mpt_pkg::BTN_W-1:0]       button_bits,
   output logic [ps2mpt_pkg::BTN_W-1:0]       last_button_bits,
   output logic signed [ps2mpt_pkg::SCROLL_W-1:0] scroll_total
);
   import ps2mpt_pkg::*;

   // Wide enough for the screen and for the reset position
   localparam int XW = ($clog2(SCREEN_WIDTH) > 9) ? $clog2(SCREEN_WIDTH) : 9;
   localparam int YW = ($clog2(SCREEN_HEIGHT) > 8) ? $clog2(SCREEN_HEIGHT) : 8;
   localparam logic signed [XW+1:0] X_MAX = (XW+2)'(SCREEN_WIDTH - 1);
   localparam logic signed [YW+1:0] Y_MAX = (YW+2)'(SCREEN_HEIGHT - 1);

   logic                 out_valid_ff, out_valid_in;
   logic [XW-1:0]        cursor_x_ff, cursor_x_in;
   logic [YW-1:0]        cursor_y_ff, cursor_y_in;
   logic [BTN_W-1:0]     buttons_now_ff, buttons_before_ff;
   logic [SCROLL_W-1:0]  wheel_sum_ff, wheel_sum_in;

   logic signed [8:0]    dx, dy;
   logic signed [XW+1:0] sum_x;
   logic signed [YW+1:0] sum_y;

   assign stall = out_valid_ff & ~rsp_ready;

   assign dx    = {pkt.x_sign, pkt.x_lo};
   assign dy    = {pkt.y_sign, pkt.y_lo};
   assign sum_x = $signed({2'b00, cursor_x_ff}) + (XW+2)'(dx);
   assign sum_y = $signed({2'b00, cursor_y_ff}) - (YW+2)'(dy);

   always_comb begin
      priority if (sum_x < 0) begin
         cursor_x_in = '0;
      end else if (sum_x > X_MAX) begin
         cursor_x_in = X_MAX[XW-1:0];
      end else begin
         cursor_x_in = sum_x[XW-1:0];
      end
      priority if (sum_y < 0) begin
         cursor_y_in = '0;
      end else if (sum_y > Y_MAX) begin
         cursor_y_in = Y_MAX[YW-1:0];
      end else begin
         cursor_y_in = sum_y[YW-1:0];
      end
   end

   assign wheel_sum_in = pkt.scroll_en
                         ? wheel_sum_ff + {{8{pkt.scroll_byte[7]}}, pkt.scroll_byte}
                         : wheel_sum_ff;

   assign out_valid_in = pkt.fire ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff      <= 1'b0;
         cursor_x_ff       <= XW'(CURSOR_X_RESET);
         cursor_y_ff       <= YW'(CURSOR_Y_RESET);
         buttons_now_ff    <= '0;
         buttons_before_ff <= '0;
         wheel_sum_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pkt.fire) begin
            cursor_x_ff       <= cursor_x_in;
            cursor_y_ff       <= cursor_y_in;
            buttons_before_ff <= buttons_now_ff;
            buttons_now_ff    <= pkt.buttons;
            wheel_sum_ff      <= wheel_sum_in;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign pos_x            = POS_X_W'(cursor_x_ff);
   assign pos_y            = POS_Y_W'(cursor_y_ff);
   assign button_bits      = buttons_now_ff;
   assign last_button_bits = buttons_before_ff;
   assign scroll_total     = $signed(wheel_sum_ff);

endmodule
`default_nettype wire

// ----- hdl/ps2mpt_mouse_packet_tracker_unit.sv -----
// Top level of the PS/2 mouse packet tracker.
`default_nettype none
`default_nettype wire

// ----- hdl/ps2_mouse_packet_tracker_unit.sv -----
// Last byte of a packet: input register, then the tracker's result register.
// Throughput: one byte per cycle; the input register feeds the tracker's result
//   register directly, and only a result waiting on rsp_ready holds the input.
// Reset (synchronous, active high): byte count 0, cursor at 320/240, buttons and
//   scroll total 0, wheel mode off, no item in flight.
// Top level of the PS/2 mouse packet tracker.
`default_nettype none
module ps2_mouse_packet_tracker_unit #(
   parameter int SCREEN_WIDTH  = ps2mpt_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = ps2mpt_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   ps2mpt_req_if.sink         req_ch,
   ps2mpt_rsp_if.source       rsp_ch,
   ps2mpt_csr_if.sink         csr_ch
);
   import ps2mpt_pkg::*;

   // Mode register; written by user only while no packet in flight; unenforced
   logic    wheel_mode_ff;
   logic    stall;
   pkt_type pkt;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_mode_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         wheel_mode_ff <= csr_ch.wheel_mode;
      end
   end

   // Stage 1: byte register, sync check, packet assembly
   ps2mpt_assembler u_assembler (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .from_aux   (req_ch.from_aux),
      .data_byte  (req_ch.data_byte),
      .wheel_mode (wheel_mode_ff),
      .stall      (stall),
      .pkt        (pkt)
   );

   // Stage 2: cursor clamp, buttons, scroll; state regs drive the result item
   ps2mpt_tracker #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_tracker (
      .clock            (clock),
      .reset            (reset),
      .pkt              (pkt),
      .stall            (stall),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .pos_x            (rsp_ch.pos_x),
      .pos_y            (rsp_ch.pos_y),
      .button_bits      (rsp_ch.button_bits),
      .last_button_bits (rsp_ch.last_button_bits),
      .scroll_total     (rsp_ch.scroll_total)
   );

endmodule
`default_nettype wire

// ----- tb/sv/ps2mpt_motion_checker.sv -----
// Checker for the PS/2 mouse packet tracker: predicts cursor reports and compares them.
`timescale 1ns / 100ps
module ps2mpt_motion_checker #(
   parameter int SCREEN_WIDTH  = ps2mpt_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = ps2mpt_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   ps2mpt_req_if req_ch,
   ps2mpt_rsp_if rsp_ch,
   ps2mpt_csr_if csr_ch,
   output int    mismatch_count,
   output int    reports_due
);
   import ps2mpt_pkg::*;

   typedef struct packed {
      logic [POS_X_W-1:0]  pos_x;
      logic [POS_Y_W-1:0]  pos_y;
      logic [BTN_W-1:0]    buttons;
      logic [BTN_W-1:0]    last_buttons;
      logic [SCROLL_W-1:0] scroll;
   } cursor_report_type;

   cursor_report_type   report_q[$];

   // tracked copy of the block's state
   logic                wheel_on;
   logic [1:0]          bytes_held;
   logic [7:0]          held[3];
   int                  col;
   int                  row;
   logic [BTN_W-1:0]    btn_now;
   logic [BTN_W-1:0]    btn_prev;
   logic [SCROLL_W-1:0] wheel_total;

   function automatic int clamp_to(input int v, input int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   // one accepted byte; queues a report when a good packet completes
   task automatic take_byte(input logic aux, input logic [7:0] b);
      logic [1:0]        last_idx;
      logic [7:0]        head;
      int                dx;
      int                dy;
      cursor_report_type rep;
      last_idx = wheel_on ? CNT_LAST_WHL : CNT_LAST_STD;
      if (!aux) return;
      if (bytes_held == CNT_FIRST && !b[HDR_SYNC_BIT]) return;
      if (bytes_held < last_idx) begin
         held[bytes_held] = b;
         bytes_held++;
         return;
      end
      // this byte closes the packet
      if (bytes_held != CNT_LAST_WHL) held[bytes_held] = b;
      bytes_held = CNT_FIRST;
      head = held[0];
      if (head[HDR_XOVF_BIT] || head[HDR_YOVF_BIT]) return;
      btn_prev = btn_now;
      btn_now  = head[BTN_W-1:0];
      dx = int'(held[1]) - (head[HDR_XSIGN_BIT] ? 256 : 0);
      dy = int'(held[2]) - (head[HDR_YSIGN_BIT] ? 256 : 0);
      col = clamp_to(col + dx, SCREEN_WIDTH - 1);
      row = clamp_to(row - dy, SCREEN_HEIGHT - 1);
      if (wheel_on) wheel_total = wheel_total + {{8{b[7]}}, b};
      rep.pos_x        = col[POS_X_W-1:0];
      rep.pos_y        = row[POS_Y_W-1:0];
      rep.buttons      = btn_now;
      rep.last_buttons = btn_prev;
      rep.scroll       = wheel_total;
      report_q.push_back(rep);
   endtask

   task automatic note_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   task automatic check_report();
      cursor_report_type want;
      if (report_q.size() == 0) begin
         mismatch_count++;
         $display("%0t: unexpected report, expected none, actual x=%0d y=%0d",
                  $time, rsp_ch.pos_x, rsp_ch.pos_y);
         return;
      end
      want = report_q.pop_front();
      note_field("pos_x", want.pos_x, rsp_ch.pos_x);
      note_field("pos_y", want.pos_y, rsp_ch.pos_y);
      note_field("button_bits", want.buttons, rsp_ch.button_bits);
      note_field("last_button_bits", want.last_buttons, rsp_ch.last_button_bits);
      note_field("scroll_total", $signed(want.scroll), rsp_ch.scroll_total);
   endtask

   initial begin
      mismatch_count = 0;
      reports_due    = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         report_q.delete();
         wheel_on    = 1'b0;
         bytes_held  = CNT_FIRST;
         held[0]     = '0;
         held[1]     = '0;
         held[2]     = '0;
         col         = CURSOR_X_RESET;
         row         = CURSOR_Y_RESET;
         btn_now     = '0;
         btn_prev    = '0;
         wheel_total = '0;
      end else begin
         // reports first: one taken at this edge never belongs to a byte taken here
         if (rsp_ch.valid && rsp_ch.ready) check_report();
         if (csr_ch.valid && csr_ch.ready) wheel_on = csr_ch.wheel_mode;
         if (req_ch.valid && req_ch.ready) take_byte(req_ch.from_aux, req_ch.data_byte);
      end
      reports_due = report_q.size();
   end
endmodule

// ----- tb/sv/tb.sv -----
// Top of the PS/2 mouse packet tracker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;
   import ps2mpt_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 1900;
   localparam int QUIET_AFTER   = 1600;  // no idling once more than this many random items went in
   localparam int LONG_HOLD     = 300;   // receiver hold-off, cycles
   localparam int SETTLE_CYCLES = 8;     // lets bytes in the pipe drain before a mode write
   localparam int DRAIN_CYCLES  = 10;

   // header byte flags
   localparam logic [7:0] SYNC  = 8'(1 << HDR_SYNC_BIT);
   localparam logic [7:0] XSIGN = 8'(1 << HDR_XSIGN_BIT);
   localparam logic [7:0] YSIGN = 8'(1 << HDR_YSIGN_BIT);
   localparam logic [7:0] XOVF  = 8'(1 << HDR_XOVF_BIT);
   localparam logic [7:0] YOVF  = 8'(1 << HDR_YOVF_BIT);

   logic clock;
   logic reset;
   int   cycles = 0;
   int   mismatch_count;
   int   reports_due;
   logic wheel_sel;      // packet length the sender builds for
   bit   quiet;          // no idling on either side
   bit   hold_rsp_req;   // asks the receiver for one long hold-off
   int   aux_items;
   int   phase;
   int   burst;
   int   kind;
   logic [7:0] head;

   ps2mpt_req_if req_if();
   ps2mpt_rsp_if rsp_if();
   ps2mpt_csr_if csr_if();

   ps2_mouse_packet_tracker_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   ps2mpt_motion_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_if),
      .rsp_ch         (rsp_if),
      .csr_ch         (csr_if),
      .mismatch_count (mismatch_count),
      .reports_due    (reports_due)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog: a hung handshake or a missing report ends here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: short random stalls, plus one long hold-off on request so the
   // block backs up and has to push back on its input.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_if.ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Offer one byte, maybe after a gap, and wait for it to be taken.
   // Returns right after the accepting edge with valid still high.
   task automatic put_byte(input logic aux, input logic [7:0] b);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.from_aux  <= aux;
      req_if.data_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      if (aux) aux_items++;
   endtask

   // Full packet for the current mode; the scroll byte goes out in wheel mode only.
   task automatic put_packet(input logic [7:0] hdr, input logic [7:0] dx,
                             input logic [7:0] dy, input logic [7:0] whl);
      put_byte(1'b1, hdr);
      put_byte(1'b1, dx);
      put_byte(1'b1, dy);
      if (wheel_sel) put_byte(1'b1, whl);
   endtask

   // Mode write with the block idle: all reports in, then a short settle so
   // bytes that make no report are through the pipe as well.
   task automatic write_mode(input logic m);
      @(negedge clock);
      req_if.valid <= 1'b0;
      wait (reports_due == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_if.valid      <= 1'b1;
      csr_if.wheel_mode <= m;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      wheel_sel = m;
   endtask

   initial begin
      req_if.valid      = 1'b0;
      req_if.from_aux   = 1'b0;
      req_if.data_byte  = '0;
      csr_if.valid      = 1'b0;
      csr_if.wheel_mode = 1'b0;
      reset             = 1'b1;
      wheel_sel         = 1'b0;
      quiet             = 1'b0;
      hold_rsp_req      = 1'b0;
      aux_items         = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part, three-byte mode out of reset ---
      put_byte(1'b0, 8'hFF);                       // keyboard byte, ignored
      put_byte(1'b1, ~SYNC);                       // no sync bit as first byte: dropped
      put_packet(SYNC | 8'h07, 8'hFF, 8'hFF, 8'h00);   // x 575, y clamps at top
      put_packet(SYNC | YSIGN | 8'h04, 8'hFF, 8'h00, 8'h00); // x clamps at right edge
      put_packet(SYNC | XSIGN | YSIGN | 8'h02, 8'h00, 8'h00, 8'h00); // y clamps at bottom
      put_packet(SYNC | XSIGN | 8'h01, 8'h00, 8'h01, 8'h00);
      put_packet(SYNC | XSIGN, 8'h00, 8'h00, 8'h00);   // x clamps at left edge
      put_packet(SYNC | XOVF | YOVF | 8'h07, 8'h12, 8'h34, 8'h00); // overflow: discarded
      // keyboard byte inside a packet changes nothing
      put_byte(1'b1, SYNC | 8'h03);
      put_byte(1'b0, 8'h55);
      put_byte(1'b1, 8'h10);
      put_byte(1'b1, 8'hF0);

      // wheel mode: scroll byte extremes
      write_mode(1'b1);
      put_packet(SYNC | 8'h01, 8'h01, 8'h01, 8'h7F);
      put_packet(SYNC | YOVF, 8'h01, 8'h01, 8'h55);    // overflow in wheel mode
      put_packet(SYNC, 8'h00, 8'h00, 8'h80);

      // mode flips with a packet partly held
      put_byte(1'b1, SYNC | 8'h02);                // three bytes held, then 3-byte mode:
      put_byte(1'b1, 8'h05);                       // the next byte closes the packet
      put_byte(1'b1, 8'h06);                       // and is not a scroll byte
      write_mode(1'b0);
      put_byte(1'b1, 8'h80);
      put_byte(1'b1, SYNC | 8'h04);                // one byte held, then wheel mode
      write_mode(1'b1);
      put_byte(1'b1, 8'h07);
      put_byte(1'b1, 8'hF9);
      put_byte(1'b1, 8'hFF);
      put_byte(1'b1, SYNC | XSIGN);                // two bytes held, then 3-byte mode
      put_byte(1'b1, 8'hF0);
      write_mode(1'b0);
      put_byte(1'b1, 8'h20);

      // --- random part: mostly good packets, some noise and broken packets ---
      aux_items = 0;
      phase     = 0;
      while (aux_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) write_mode(1'($urandom_range(0, 1)));
         quiet = (aux_items > QUIET_AFTER) || ($urandom_range(0, 3) == 0);
         if (phase == 2) hold_rsp_req = 1'b1;
         burst = (phase == 2) ? 60 : $urandom_range(20, 60);
         repeat (burst) begin
            kind = $urandom_range(0, 19);
            head = 8'($urandom_range(0, 255)) | SYNC;
            if (kind == 0) begin
               put_byte(1'b0, 8'($urandom_range(0, 255)));
            end else if (kind == 1) begin
               put_byte(1'b1, 8'($urandom_range(0, 255)));
            end else if (kind == 2) begin
               // packet cut short; the next header lands mid-packet
               put_byte(1'b1, head);
               repeat ($urandom_range(0, 1)) put_byte(1'b1, 8'($urandom_range(0, 255)));
            end else begin
               if ($urandom_range(0, 7) != 0) head = head & ~(XOVF | YOVF);
               put_packet(head, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            end
         end
         phase++;
      end

      // drain and give the verdict
      @(negedge clock);
      req_if.valid <= 1'b0;
      wait (reports_due == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
